FILE: rtl/vhd_pkg.sv
// Package for vector_heading_degrees: shared widths, side-band struct,
// angle constants and the arctangent table. No dependencies.
`default_nettype none
package vhd_pkg;

  localparam int unsigned RATIO_STEPS = 100;
  // Quotient bits: the rounded ratio never exceeds RATIO_STEPS.
  localparam int unsigned QUOT_W      = $clog2(RATIO_STEPS + 1);
  localparam int unsigned ANG_W       = 6;   // table entries 0..45
  localparam int unsigned HEAD_W      = 9;

  localparam logic [HEAD_W-1:0] DEG_90  = 9'd90;
  localparam logic [HEAD_W-1:0] DEG_180 = 9'd180;
  localparam logic [HEAD_W-1:0] DEG_360 = 9'd360;

  // Flags that ride along the divider chain with each word.
  typedef struct packed {
    logic zero;    // both components zero
    logic oct;     // |x| >= |y|: angle is taken from 90
    logic x_neg;
    logic y_neg;
  } vhd_side_t;

  // Index is round(tan * 100), entry is the angle in whole degrees.
  localparam logic [ANG_W-1:0] ATAN_DEG [0:RATIO_STEPS] = '{
     6'd0,  6'd1,  6'd1,  6'd2,  6'd3,  6'd3,  6'd4,  6'd4,  6'd5,  6'd5,
     6'd6,  6'd7,  6'd7,  6'd8,  6'd8,  6'd9,  6'd9, 6'd10, 6'd10, 6'd11,
    6'd12, 6'd12, 6'd13, 6'd13, 6'd14, 6'd14, 6'd15, 6'd15, 6'd16, 6'd16,
    6'd17, 6'd17, 6'd18, 6'd19, 6'd19, 6'd20, 6'd20, 6'd21, 6'd21, 6'd22,
    6'd22, 6'd23, 6'd23, 6'd24, 6'd24, 6'd24, 6'd25, 6'd25, 6'd26, 6'd26,
    6'd27, 6'd27, 6'd28, 6'd28, 6'd29, 6'd29, 6'd29, 6'd30, 6'd30, 6'd31,
    6'd31, 6'd32, 6'd32, 6'd32, 6'd33, 6'd33, 6'd34, 6'd34, 6'd34, 6'd35,
    6'd35, 6'd36, 6'd36, 6'd36, 6'd37, 6'd37, 6'd37, 6'd38, 6'd38, 6'd38,
    6'd39, 6'd39, 6'd40, 6'd40, 6'd40, 6'd41, 6'd41, 6'd41, 6'd42, 6'd42,
    6'd42, 6'd42, 6'd43, 6'd43, 6'd43, 6'd44, 6'd44, 6'd44, 6'd45, 6'd45,
    6'd45
  };

endpackage
`default_nettype wire

FILE: rtl/vhd_front.sv
// Input stage: magnitudes, octant fold and scaled numerator, registered.
// Depends on vhd_pkg.
`default_nettype none
module vhd_front #(
  parameter int unsigned COORD_BITS = 13
) (
  input  logic                                        clk_i,
  input  logic                                        rst_ni,
  input  logic                                        valid_i,
  input  logic signed [COORD_BITS-1:0]                x_value_i,
  input  logic signed [COORD_BITS-1:0]                y_value_i,
  output logic                                        valid_o,
  output vhd_pkg::vhd_side_t                          side_o,
  output logic [COORD_BITS-1:0]                       div_o,
  output logic [COORD_BITS+vhd_pkg::QUOT_W-1:0]       rem_o
);

  localparam int unsigned NUM_W = COORD_BITS + vhd_pkg::QUOT_W;

  logic [COORD_BITS-1:0] ax, ay, mn, mx;
  logic                  oct;
  logic [NUM_W-1:0]      num;
  vhd_pkg::vhd_side_t    side_d;

  // Two's complement negate in the same width also covers the most negative value.
  assign ax  = x_value_i[COORD_BITS-1] ? (~x_value_i + 1'b1) : x_value_i;
  assign ay  = y_value_i[COORD_BITS-1] ? (~y_value_i + 1'b1) : y_value_i;
  assign oct = (ax >= ay);
  assign mn  = oct ? ay : ax;
  assign mx  = oct ? ax : ay;
  // round half up: (100 * min + max / 2) / max
  assign num = NUM_W'(mn) * NUM_W'(vhd_pkg::RATIO_STEPS) + NUM_W'(mx >> 1);

  always_comb begin
    side_d.zero  = (ax == '0) && (ay == '0);
    side_d.oct   = oct;
    side_d.x_neg = x_value_i[COORD_BITS-1];
    side_d.y_neg = y_value_i[COORD_BITS-1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    side_o <= side_d;
    div_o  <= mx;
    rem_o  <= num;
  end

endmodule
`default_nettype wire

FILE: rtl/vhd_div_cell.sv
// One restoring-division cell: resolves quotient bit QBIT and hands the
// partial remainder to the next cell. Depends on vhd_pkg.
`default_nettype none
module vhd_div_cell #(
  parameter int unsigned COORD_BITS = 13,
  parameter int unsigned QBIT       = 0
) (
  input  logic                                        clk_i,
  input  logic                                        rst_ni,
  input  logic                                        valid_i,
  input  vhd_pkg::vhd_side_t                          side_i,
  input  logic [COORD_BITS-1:0]                       div_i,
  input  logic [COORD_BITS+vhd_pkg::QUOT_W-1:0]       rem_i,
  input  logic [vhd_pkg::QUOT_W-1:0]                  quot_i,
  output logic                                        valid_o,
  output vhd_pkg::vhd_side_t                          side_o,
  output logic [COORD_BITS-1:0]                       div_o,
  output logic [COORD_BITS+vhd_pkg::QUOT_W-1:0]       rem_o,
  output logic [vhd_pkg::QUOT_W-1:0]                  quot_o
);

  localparam int unsigned NUM_W = COORD_BITS + vhd_pkg::QUOT_W;

  logic [NUM_W:0]                trial;
  logic                          take;
  logic [NUM_W-1:0]              rem_d;
  logic [vhd_pkg::QUOT_W-1:0]    quot_d;

  assign trial  = {1'b0, rem_i} - {1'b0, (NUM_W'(div_i) << QBIT)};
  assign take   = ~trial[NUM_W];
  assign rem_d  = take ? trial[NUM_W-1:0] : rem_i;
  assign quot_d = quot_i | (vhd_pkg::QUOT_W'(take) << QBIT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    side_o <= side_i;
    div_o  <= div_i;
    rem_o  <= rem_d;
    quot_o <= quot_d;
  end

endmodule
`default_nettype wire

FILE: rtl/vhd_back.sv
// Output stage: arctangent lookup, octant and quadrant unfold, registered.
// Depends on vhd_pkg.
`default_nettype none
module vhd_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  input  vhd_pkg::vhd_side_t            side_i,
  input  logic [vhd_pkg::QUOT_W-1:0]    quot_i,
  output logic                          done_o,
  output logic [vhd_pkg::HEAD_W-1:0]    heading_o,
  output logic                          zero_vector_o
);

  logic [vhd_pkg::QUOT_W-1:0]  idx;
  logic [vhd_pkg::HEAD_W-1:0]  tab, ang, raw, heading_d;

  assign idx = (quot_i > vhd_pkg::QUOT_W'(vhd_pkg::RATIO_STEPS))
             ? vhd_pkg::QUOT_W'(vhd_pkg::RATIO_STEPS) : quot_i;
  assign tab = vhd_pkg::HEAD_W'(vhd_pkg::ATAN_DEG[idx]);
  assign ang = side_i.oct ? (vhd_pkg::DEG_90 - tab) : tab;

  always_comb begin
    case ({side_i.x_neg, side_i.y_neg})
      2'b00:   raw = ang;
      2'b01:   raw = vhd_pkg::DEG_180 - ang;
      2'b10:   raw = vhd_pkg::DEG_360 - ang;
      default: raw = vhd_pkg::DEG_180 + ang;
    endcase
    if (side_i.zero) begin
      heading_d = '0;
    end else if (raw >= vhd_pkg::DEG_360) begin
      heading_d = raw - vhd_pkg::DEG_360;   // full turn wraps to north
    end else begin
      heading_d = raw;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_o <= 1'b0;
    end else begin
      done_o <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    heading_o     <= heading_d;
    zero_vector_o <= side_i.zero;
  end

endmodule
`default_nettype wire

FILE: rtl/vector_heading_degrees.sv
// Top level of vector_heading_degrees: input stage, chain of division
// cells, lookup stage. Depends on vhd_pkg, vhd_front, vhd_div_cell, vhd_back.
//
// Usage:
//   Drive x_value_i / y_value_i (signed two's complement) and pulse start.
//   A word is taken at every clock edge where start is high and busy is low;
//   busy is held low, so one vector can enter every cycle.
//   The heading (whole degrees from +y toward +x, 0..359) and zero_vector_o
//   appear for exactly one cycle with done_o high, after the word has passed
//   through the registers in order: one input stage, one division cell per
//   quotient bit (seven), one lookup stage. Words leave in order.
//   Throughput is one vector per cycle; each cell of the restoring divider
//   chain resolves one quotient bit and passes its remainder on each cycle.
//   A zero vector gives heading 0 with zero_vector_o set.
//   Reset clears the valid bits of every stage, dropping words in flight.
//   There is no backpressure: the receiver must take done_o when it comes.
`default_nettype none
module vector_heading_degrees #(
  parameter int unsigned COORD_BITS = 13
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [COORD_BITS-1:0]  x_value_i,
  input  logic signed [COORD_BITS-1:0]  y_value_i,
  output logic                          done_o,
  output logic [vhd_pkg::HEAD_W-1:0]    heading_o,
  output logic                          zero_vector_o
);

  localparam int unsigned QW      = vhd_pkg::QUOT_W;
  localparam int unsigned NUM_W   = COORD_BITS + QW;
  localparam int unsigned LATENCY = QW + 2;

  logic                  valid_s [0:QW];
  vhd_pkg::vhd_side_t    side_s  [0:QW];
  logic [COORD_BITS-1:0] div_s   [0:QW];
  logic [NUM_W-1:0]      rem_s   [0:QW];
  logic [QW-1:0]         quot_s  [0:QW];

  assign busy      = 1'b0;
  assign quot_s[0] = '0;

  vhd_front #(
    .COORD_BITS (COORD_BITS)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (start),
    .x_value_i (x_value_i),
    .y_value_i (y_value_i),
    .valid_o   (valid_s[0]),
    .side_o    (side_s[0]),
    .div_o     (div_s[0]),
    .rem_o     (rem_s[0])
  );

  // Cell j settles quotient bit QW-1-j, most significant first.
  for (genvar j = 0; j < QW; j++) begin : g_cell
    vhd_div_cell #(
      .COORD_BITS (COORD_BITS),
      .QBIT       (QW - 1 - j)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (valid_s[j]),
      .side_i  (side_s[j]),
      .div_i   (div_s[j]),
      .rem_i   (rem_s[j]),
      .quot_i  (quot_s[j]),
      .valid_o (valid_s[j+1]),
      .side_o  (side_s[j+1]),
      .div_o   (div_s[j+1]),
      .rem_o   (rem_s[j+1]),
      .quot_o  (quot_s[j+1])
    );
  end

  vhd_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (valid_s[QW]),
    .side_i        (side_s[QW]),
    .quot_i        (quot_s[QW]),
    .done_o        (done_o),
    .heading_o     (heading_o),
    .zero_vector_o (zero_vector_o)
  );

`ifndef SYNTHESIS
  a_heading_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> heading_o < vhd_pkg::DEG_360)
    else $error("heading out of range");

  a_zero_heading: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && zero_vector_o |-> heading_o == '0)
    else $error("zero vector with nonzero heading");

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |-> ##LATENCY done_o)
    else $error("result missing at expected latency");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start, LATENCY))
    else $error("result without a matching input word");
`endif

endmodule
`default_nettype wire
